// ===== src/bdq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants of the bounded deque with match count.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int DEPTH   = 64;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int OCC_W   = $clog2(DEPTH + 1);
    localparam int WORD_W  = 32;
    localparam int CMD_W   = 3;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;

    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);
    localparam logic [OCC_W-1:0] FULL_OCC  = OCC_W'(DEPTH);

    typedef logic [WORD_W-1:0] t_word;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT  = 3'd0,
        CMD_PUSH_BACK   = 3'd1,
        CMD_POP_FRONT   = 3'd2,
        CMD_POP_BACK    = 3'd3,
        CMD_COUNT_ALL   = 3'd4,
        CMD_COUNT_VALUE = 3'd5
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_FROM_PREV,
        CELL_FROM_NEXT,
        CELL_LOAD
    } t_cell_op;

    typedef enum logic [1:0] {
        ROW_HOLD,
        ROW_PUSH_FRONT,
        ROW_PUSH_BACK,
        ROW_ROTATE
    } t_row_mode;

    typedef enum logic {
        ST_IDLE,
        ST_COUNT
    } t_state;

    typedef struct packed {
        t_row_mode        mode;
        logic [IDX_W-1:0] slot;
        t_word            data;
    } t_row_ctl;

endpackage

// ===== src/bdq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_cell
// One storage cell of the deque row: holds one entry and can take the entry
// of either neighbor or a new value.
// ----------------------------------------------------------------------------
module bdq_cell (
    input  logic              i_clk,
    input  bdq_pkg::t_cell_op i_op,
    input  bdq_pkg::t_word    i_prev_data,
    input  bdq_pkg::t_word    i_next_data,
    input  bdq_pkg::t_word    i_load_data,
    output bdq_pkg::t_word    o_data
);

    bdq_pkg::t_word r_data;
    bdq_pkg::t_word n_data;

    always_comb begin
        case (i_op)
            bdq_pkg::CELL_FROM_PREV: n_data = i_prev_data;
            bdq_pkg::CELL_FROM_NEXT: n_data = i_next_data;
            bdq_pkg::CELL_LOAD:      n_data = i_load_data;
            default:                 n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ===== src/bdq_row.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_row
// Row of cells holding the queue with the front entry in cell 0. Pushing at
// the front shifts the row toward the back, rotating moves every entry one
// cell toward the front with cell 0 wrapping to the last cell.
// ----------------------------------------------------------------------------
module bdq_row (
    input  logic              i_clk,
    input  bdq_pkg::t_row_ctl i_ctl,
    output bdq_pkg::t_word    o_front
);

    bdq_pkg::t_word   w_data [bdq_pkg::DEPTH];
    bdq_pkg::t_cell_op w_op  [bdq_pkg::DEPTH];

    always_comb begin
        for (int i = 0; i < bdq_pkg::DEPTH; i++) begin
            case (i_ctl.mode)
                bdq_pkg::ROW_PUSH_FRONT:
                    w_op[i] = (i == 0) ? bdq_pkg::CELL_LOAD : bdq_pkg::CELL_FROM_PREV;
                bdq_pkg::ROW_PUSH_BACK:
                    w_op[i] = (i_ctl.slot == bdq_pkg::IDX_W'(i)) ? bdq_pkg::CELL_LOAD
                                                                 : bdq_pkg::CELL_HOLD;
                bdq_pkg::ROW_ROTATE:
                    w_op[i] = bdq_pkg::CELL_FROM_NEXT;
                default:
                    w_op[i] = bdq_pkg::CELL_HOLD;
            endcase
        end
    end

    for (genvar g = 0; g < bdq_pkg::DEPTH; g++) begin : g_cell
        bdq_cell u_cell (
            .i_clk       (i_clk),
            .i_op        (w_op[g]),
            .i_prev_data (w_data[(g + bdq_pkg::DEPTH - 1) % bdq_pkg::DEPTH]),
            .i_next_data (w_data[(g + 1) % bdq_pkg::DEPTH]),
            .i_load_data (i_ctl.data),
            .o_data      (w_data[g])
        );
    end

    assign o_front = w_data[0];

endmodule

// ===== src/bounded_deque_with_match_count_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_match_count_core
// Bounded deque of 32-bit values held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry i_cmd and i_value and are taken when i_valid is high
//   and o_stall is low. Each input beat produces exactly one output beat on
//   o_status / o_count, taken when o_valid is high and i_stall is low.
//   Push, pop and count-all beats give their result in the cycle after they are
//   taken and a new beat can be taken every cycle while the output drains.
//   A count-value beat rotates the whole row of 64 cells past the compare
//   at cell 0, one cell per cycle, and its result is registered at the last
//   step of the walk; o_stall stays high during that walk. After the walk every
//   entry is back in its original cell.
//   Pushes into a full queue report full and drop the value; pops from an
//   empty queue report empty and change nothing.
//   While the receiver stalls, the output beat holds and o_stall rises until
//   the pending result is taken.
//   A synchronous reset empties the queue and drops any pending result; the
//   stored values themselves are not cleared.
// ----------------------------------------------------------------------------
module bounded_deque_with_match_count_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [bdq_pkg::CMD_W-1:0]         i_cmd,
    input  logic signed [bdq_pkg::WORD_W-1:0] i_value,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [bdq_pkg::STAT_W-1:0]        o_status,
    output logic [bdq_pkg::COUNT_W-1:0]       o_count
);

    bdq_pkg::t_state           r_state, n_state;
    logic [bdq_pkg::OCC_W-1:0] r_occ, n_occ;
    logic [bdq_pkg::IDX_W-1:0] r_step, n_step;
    logic [bdq_pkg::OCC_W-1:0] r_match, n_match;
    bdq_pkg::t_word            r_value, n_value;
    logic                      r_out_valid, n_out_valid;
    bdq_pkg::t_status          r_status, n_status;
    logic [bdq_pkg::COUNT_W-1:0] r_count, n_count;

    bdq_pkg::t_row_ctl w_ctl;
    bdq_pkg::t_word    w_front;
    logic              w_accept;
    logic              w_out_free;
    logic              w_full;
    logic              w_empty;
    logic              w_hit;
    logic [bdq_pkg::OCC_W-1:0] w_total;

    assign w_out_free = !r_out_valid || !i_stall;
    assign o_stall    = (r_state != bdq_pkg::ST_IDLE) || !w_out_free;
    assign w_accept   = i_valid && !o_stall;
    assign w_full     = (r_occ == bdq_pkg::FULL_OCC);
    assign w_empty    = (r_occ == '0);

    // Only the first occupancy positions of the walk hold live entries.
    assign w_hit   = (w_front == r_value) && ({1'b0, r_step} < r_occ);
    assign w_total = r_match + bdq_pkg::OCC_W'(w_hit);

    always_comb begin
        n_state     = r_state;
        n_occ       = r_occ;
        n_step      = r_step;
        n_match     = r_match;
        n_value     = r_value;
        n_out_valid = r_out_valid && i_stall;
        n_status    = r_status;
        n_count     = r_count;
        w_ctl.mode  = bdq_pkg::ROW_HOLD;
        w_ctl.slot  = r_occ[bdq_pkg::IDX_W-1:0];
        w_ctl.data  = i_value;

        case (r_state)
            bdq_pkg::ST_COUNT: begin
                w_ctl.mode = bdq_pkg::ROW_ROTATE;
                n_step     = r_step + 1'b1;
                n_match    = w_total;
                if (r_step == bdq_pkg::LAST_SLOT) begin
                    n_state     = bdq_pkg::ST_IDLE;
                    n_out_valid = 1'b1;
                    n_status    = bdq_pkg::STAT_OK;
                    n_count     = bdq_pkg::COUNT_W'(w_total);
                end
            end
            default: begin
                if (w_accept) begin
                    n_out_valid = 1'b1;
                    n_status    = bdq_pkg::STAT_OK;
                    case (i_cmd)
                        bdq_pkg::CMD_PUSH_FRONT: begin
                            if (w_full) begin
                                n_status = bdq_pkg::STAT_FULL;
                            end else begin
                                w_ctl.mode = bdq_pkg::ROW_PUSH_FRONT;
                                n_occ      = r_occ + 1'b1;
                            end
                        end
                        bdq_pkg::CMD_PUSH_BACK: begin
                            if (w_full) begin
                                n_status = bdq_pkg::STAT_FULL;
                            end else begin
                                w_ctl.mode = bdq_pkg::ROW_PUSH_BACK;
                                n_occ      = r_occ + 1'b1;
                            end
                        end
                        bdq_pkg::CMD_POP_FRONT: begin
                            if (w_empty) begin
                                n_status = bdq_pkg::STAT_EMPTY;
                            end else begin
                                // The old front wraps into the last cell, outside the live entries.
                                w_ctl.mode = bdq_pkg::ROW_ROTATE;
                                n_occ      = r_occ - 1'b1;
                            end
                        end
                        bdq_pkg::CMD_POP_BACK: begin
                            if (w_empty) begin
                                n_status = bdq_pkg::STAT_EMPTY;
                            end else begin
                                n_occ = r_occ - 1'b1;
                            end
                        end
                        bdq_pkg::CMD_COUNT_VALUE: begin
                            n_out_valid = 1'b0;
                            n_state     = bdq_pkg::ST_COUNT;
                            n_step      = '0;
                            n_match     = '0;
                            n_value     = i_value;
                        end
                        default: ;
                    endcase
                    n_count = bdq_pkg::COUNT_W'(n_occ);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bdq_pkg::ST_IDLE;
            r_occ       <= '0;
            r_step      <= '0;
            r_match     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_step      <= n_step;
            r_match     <= n_match;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value  <= n_value;
        r_status <= n_status;
        r_count  <= n_count;
    end

    bdq_row u_row (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .o_front (w_front)
    );

    assign o_valid  = r_out_valid;
    assign o_status = r_status;
    assign o_count  = r_count;

endmodule
